/* sv/ibeacon_advert_filter_macros.svh */
// Assertion macros used by the iBeacon advertisement filter RTL.
`ifndef IBEACON_ADVERT_FILTER_MACROS_SVH
`define IBEACON_ADVERT_FILTER_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside of reset.
`define IBF_ASSERT(lbl, clk_sig, rstn_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (prop)) \
		else $error("ibeacon_advert_filter: assertion failed");

// Checks that a condition never holds outside of reset.
`define IBF_ASSERT_NEVER(lbl, clk_sig, rstn_sig, cond) \
	`IBF_ASSERT(lbl, clk_sig, rstn_sig, !(cond))

`else

`define IBF_ASSERT(lbl, clk_sig, rstn_sig, prop)
`define IBF_ASSERT_NEVER(lbl, clk_sig, rstn_sig, cond)

`endif

`endif

/* sv/ibf_pkg.sv */
// Types, constants and register map of the iBeacon advertisement filter.
`default_nettype none

package ibf_pkg;

	// A record shorter than this many bytes is rejected as too short.
	localparam logic [4:0] MIN_FRAME_BYTES = 5'd25;

	// Byte positions inside the manufacturer data.
	localparam logic [4:0] UUID_FIRST_POS = 5'd4;
	localparam logic [4:0] UUID_LAST_POS  = 5'd19;
	localparam logic [4:0] ID_FIRST_POS   = 5'd20;
	localparam logic [4:0] ID_LAST_POS    = 5'd23;

	// iBeacon prefix: Apple company id (little-endian), type, length.
	localparam logic [7:0] IBEACON_PREFIX [4] = '{8'h4C, 8'h00, 8'h02, 8'h15};

	// Configuration port.
	localparam int CFG_ADDR_W = 6;
	localparam int CFG_DATA_W = 64;

	localparam logic [2:0] REG_MIN_RSSI    = 3'd0;
	localparam logic [2:0] REG_UUID_A_HIGH = 3'd1;
	localparam logic [2:0] REG_UUID_A_LOW  = 3'd2;
	localparam logic [2:0] REG_UUID_B_HIGH = 3'd3;
	localparam logic [2:0] REG_UUID_B_LOW  = 3'd4;

	localparam logic signed [7:0] MIN_RSSI_RESET = -8'sd70;

	typedef enum logic [2:0] {
		VERDICT_ACCEPT = 3'd0,
		VERDICT_WEAK   = 3'd1,
		VERDICT_SHORT  = 3'd2,
		VERDICT_HEADER = 3'd3,
		VERDICT_UUID   = 3'd4
	} verdict_t;

	typedef struct packed {
		logic [7:0]        data_byte;
		logic              first_byte;
		logic              last_byte;
		logic signed [7:0] signal_dbm;
		logic              empty_record;
	} in_beat_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [31:0] animal_id;
	} out_beat_t;

	typedef struct packed {
		logic signed [7:0] min_rssi;
		logic [63:0]       uuid_a_high;
		logic [63:0]       uuid_a_low;
		logic [63:0]       uuid_b_high;
		logic [63:0]       uuid_b_low;
	} cfg_t;

	typedef struct packed {
		logic [4:0]  byte_count;
		logic        header_good;
		logic        uuid_a_equal;
		logic        uuid_b_equal;
		logic        signal_pass;
		logic [31:0] id_capture;
	} record_t;

	localparam record_t RECORD_CLEAR = '{
		byte_count:   5'd0,
		header_good:  1'b1,
		uuid_a_equal: 1'b1,
		uuid_b_equal: 1'b1,
		signal_pass:  1'b0,
		id_capture:   32'd0
	};

endpackage

`default_nettype wire

/* sv/ibeacon_advert_filter.sv */
// Top level of the iBeacon advertisement filter: input stage, record logic, result stage.
//
//   Channel   Direction  Handshake              Payload
//   in        sink       in_valid / in_stall    in_beat   (one manufacturer data byte)
//   out       source     out_valid / out_stall  out_beat  (verdict and animal id)
//   cfg       APB slave  psel/penable/pready    paddr, pwdata, prdata (64-bit registers)
//
// One beat is accepted per cycle while in_stall is low. An accepted beat is registered in
// the input stage, where the record logic updates its state; a beat that closes a record
// loads the result register as it leaves the input stage, and its verdict is offered from
// that register until out_stall is low.
// Reset clears the record state, the stage valid flags and loads the register defaults.
// A stalled output only holds the input stage when the beat waiting there closes a
// record; bytes in the middle of a record keep flowing while a verdict waits.
`default_nettype none

`include "ibeacon_advert_filter_macros.svh"

module ibeacon_advert_filter import ibf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Byte stream in.
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_beat_t              in_beat,
	// Verdicts out.
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_beat_t                  out_beat,
	// Configuration.
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output logic                       pready
);

	cfg_t      cfg;
	in_beat_t  beat_s1;
	logic      valid_s1;
	out_beat_t result;
	out_beat_t result_q;
	logic      result_valid_q;
	logic      out_free;
	logic      advance;

	assign pready = 1'b1;

	ibf_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// The result register is free when empty or when its verdict is taken this cycle.
	assign out_free = !result_valid_q || !out_stall;

	// The staged beat moves on unless it closes a record and the result register is busy.
	assign advance  = valid_s1 && (!beat_s1.last_byte || out_free);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			beat_s1 <= in_beat;
		end
	end

	ibf_record u_record (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.beat    (beat_s1),
		.cfg     (cfg),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && beat_s1.last_byte) begin
			result_valid_q <= 1'b1;
		end else if (!out_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && beat_s1.last_byte) begin
			result_q <= result;
		end
	end

	assign out_valid = result_valid_q;
	assign out_beat  = result_q;

	// A verdict only appears after the input stage held the closing byte of a record.
	`IBF_ASSERT(a_verdict_from_last, clk, arst_n,
		$rose(result_valid_q) |-> $past(valid_s1 && beat_s1.last_byte))
	// Only an accepted record carries an animal id.
	`IBF_ASSERT(a_id_only_on_accept, clk, arst_n,
		(result_valid_q && result_q.verdict != VERDICT_ACCEPT) |->
		(result_q.animal_id == 32'd0))
	// Back-pressure upstream requires a staged beat that closes a record.
	`IBF_ASSERT_NEVER(a_stall_without_last, clk, arst_n,
		in_stall && !(valid_s1 && beat_s1.last_byte && result_valid_q))

endmodule

`default_nettype wire

/* sv/ibf_cfg_regs.sv */
// APB register file holding the RSSI threshold and the two expected UUIDs.
`default_nettype none

module ibf_cfg_regs import ibf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic      [CFG_DATA_W-1:0] prdata,
	output cfg_t                       cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign reg_idx = paddr[5:3];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_rssi    <= MIN_RSSI_RESET;
			cfg_q.uuid_a_high <= '0;
			cfg_q.uuid_a_low  <= '0;
			cfg_q.uuid_b_high <= '0;
			cfg_q.uuid_b_low  <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MIN_RSSI:    cfg_q.min_rssi    <= pwdata[7:0];
				REG_UUID_A_HIGH: cfg_q.uuid_a_high <= pwdata;
				REG_UUID_A_LOW:  cfg_q.uuid_a_low  <= pwdata;
				REG_UUID_B_HIGH: cfg_q.uuid_b_high <= pwdata;
				REG_UUID_B_LOW:  cfg_q.uuid_b_low  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MIN_RSSI:    prdata = {{(CFG_DATA_W-8){1'b0}}, cfg_q.min_rssi};
			REG_UUID_A_HIGH: prdata = cfg_q.uuid_a_high;
			REG_UUID_A_LOW:  prdata = cfg_q.uuid_a_low;
			REG_UUID_B_HIGH: prdata = cfg_q.uuid_b_high;
			REG_UUID_B_LOW:  prdata = cfg_q.uuid_b_low;
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* sv/ibf_record.sv */
// Per-record state: prefix check, UUID compare, id capture and the verdict.
`default_nettype none

module ibf_record import ibf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     advance,
	input  wire in_beat_t beat,
	input  wire cfg_t     cfg,
	output out_beat_t     result
);

	record_t      rec_q;
	record_t      rec_cur;
	record_t      rec_upd;
	record_t      rec_d;
	logic [4:0]   pos;
	logic [3:0]   uuid_idx;
	logic [6:0]   uuid_lsb;
	logic [127:0] uuid_a;
	logic [127:0] uuid_b;
	logic [7:0]   exp_a;
	logic [7:0]   exp_b;

	assign uuid_a = {cfg.uuid_a_high, cfg.uuid_a_low};
	assign uuid_b = {cfg.uuid_b_high, cfg.uuid_b_low};

	// UUID byte k sits at bits 127-8k down; 15-k is the bitwise inverse of k.
	assign pos      = rec_cur.byte_count;
	assign uuid_idx = pos[3:0] - UUID_FIRST_POS[3:0];
	assign uuid_lsb = {~uuid_idx, 3'b000};
	assign exp_a    = uuid_a[uuid_lsb +: 8];
	assign exp_b    = uuid_b[uuid_lsb +: 8];

	always_comb begin
		rec_cur = rec_q;
		if (beat.first_byte) begin
			rec_cur             = RECORD_CLEAR;
			rec_cur.signal_pass = !(beat.signal_dbm < cfg.min_rssi);
		end

		rec_upd = rec_cur;
		if (!beat.empty_record) begin
			case (pos) inside
				[5'd0 : UUID_FIRST_POS - 5'd1]: begin
					if (beat.data_byte != IBEACON_PREFIX[pos[1:0]]) begin
						rec_upd.header_good = 1'b0;
					end
				end
				[UUID_FIRST_POS : UUID_LAST_POS]: begin
					if (beat.data_byte != exp_a) begin
						rec_upd.uuid_a_equal = 1'b0;
					end
					if (beat.data_byte != exp_b) begin
						rec_upd.uuid_b_equal = 1'b0;
					end
				end
				[ID_FIRST_POS : ID_LAST_POS]: begin
					rec_upd.id_capture = {rec_cur.id_capture[23:0], beat.data_byte};
				end
				default: ;
			endcase
			if (pos < MIN_FRAME_BYTES) begin
				rec_upd.byte_count = pos + 5'd1;
			end
		end

		result.animal_id = '0;
		if (!rec_upd.signal_pass) begin
			result.verdict = VERDICT_WEAK;
		end else if (rec_upd.byte_count < MIN_FRAME_BYTES) begin
			result.verdict = VERDICT_SHORT;
		end else if (!rec_upd.header_good) begin
			result.verdict = VERDICT_HEADER;
		end else if (!rec_upd.uuid_a_equal && !rec_upd.uuid_b_equal) begin
			result.verdict = VERDICT_UUID;
		end else begin
			result.verdict   = VERDICT_ACCEPT;
			result.animal_id = rec_upd.id_capture;
		end

		rec_d = beat.last_byte ? RECORD_CLEAR : rec_upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= RECORD_CLEAR;
		end else if (advance) begin
			rec_q <= rec_d;
		end
	end

endmodule

`default_nettype wire
